@@ rtl/ppd_pkg.sv @@
// Shared types and constants for the pulse peak detector.
`timescale 1ns / 1ps
package ppd_pkg;

    localparam int LEVEL_W = 24;
    localparam int TIME_W  = 32;
    localparam int RATE_W  = 24;
    localparam int PEAK_W  = 15;
    localparam int PHASE_W = 2;

    localparam logic [PHASE_W-1:0] PHASE_IDLE = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_UP   = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_DOWN = 2'd2;

    localparam logic REG_UPPER = 1'b0;
    localparam logic REG_LOWER = 1'b1;

    localparam logic signed [LEVEL_W-1:0] UPPER_RESET = 24'sd512000;
    localparam logic signed [LEVEL_W-1:0] LOWER_RESET = 24'sd25600;

    // 60000 ms per minute scaled by 256 for the Q16.8 result.
    localparam logic [RATE_W-1:0] RATE_NUMERATOR = 24'd15360000;

    typedef struct packed {
        logic load;
        logic eval;
        logic rate_start;
        logic rate_store;
        logic ring_update;
        logic avg_start;
        logic avg_store;
        logic out_load;
    } ppd_cmd_t;

    typedef struct packed {
        logic beat;
        logic interval_zero;
        logic div_done;
        logic out_busy;
    } ppd_status_t;

endpackage

@@ rtl/pulse_peak_detector_bpm_core.sv @@
// Top level of the pulse peak detector with averaged beat rate.
// A sample ending no beat is loaded, evaluated, then moved to the output register when free.
// A beat runs two divisions of 24+ceil(log2(RATE_WINDOW+1)) steps on the shared divider,
// or only the averaging division when the interval is zero.
// One item is in work at a time; the next is taken while a result waits in the output register.
// Reset is asynchronous and active low; it clears the detector and the rate ring at once.
`timescale 1ns / 1ps
module pulse_peak_detector_bpm_core #(
    parameter int RATE_WINDOW = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic        cfg_addr,
    input  logic [23:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // sample_level [23:0], time_ms [55:24]
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // average_rate [23:0], peak_level [38:24], detector_phase [40:39], zeros [47:41]
    output logic [47:0] m_axis_tdata,
    // beat_found [0]
    output logic        m_axis_tuser
);
    import ppd_pkg::*;

    ppd_cmd_t           cmd;
    ppd_status_t        sts;
    logic [RATE_W-1:0]  out_rate;
    logic [PEAK_W-1:0]  out_peak;
    logic [PHASE_W-1:0] out_phase;

    ppd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ppd_datapath #(
        .RATE_WINDOW (RATE_WINDOW)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_level  (s_axis_tdata[23:0]),
        .in_time   (s_axis_tdata[55:24]),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_found (m_axis_tuser),
        .out_rate  (out_rate),
        .out_peak  (out_peak),
        .out_phase (out_phase)
    );

    assign m_axis_tdata = {7'b0, out_phase, out_peak, out_rate};

    // Only one item is in work at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in work");

    // A detected beat always leaves the detector tracing down.
    a_beat_phase: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[40:39] == PHASE_DOWN)
        else $error("beat reported outside the trace-down phase");

    // The divider finishes only while an item is in work.
    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> !s_axis_tready)
        else $error("divider finished while the block was idle");

endmodule

@@ rtl/ppd_div.sv @@
// Serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ppd_div #(
    parameter int N_W = 28,
    parameter int D_W = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic           done,
    output logic [N_W-1:0] quotient
);
    localparam int CNT_W = $clog2(N_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [D_W-1:0]   rem_reg;
    logic [N_W-1:0]   quo_reg;
    logic [D_W-1:0]   den_reg;

    logic [D_W:0]     shifted;
    logic [D_W+1:0]   diff;
    logic             fits;
    logic [D_W-1:0]   rem_next;
    logic [N_W-1:0]   quo_next;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[N_W-1]};
        diff     = {1'b0, shifted} - {2'b00, den_reg};
        fits     = ~diff[D_W+1];
        rem_next = fits ? diff[D_W-1:0] : shifted[D_W-1:0];
        quo_next = {quo_reg[N_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(N_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/ppd_ctrl.sv @@
// Controller state machine that sequences one item through the datapath.
`timescale 1ns / 1ps
module ppd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ppd_pkg::ppd_status_t sts,
    output ppd_pkg::ppd_cmd_t    cmd
);
    import ppd_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_EVAL     = 3'd1;
    localparam logic [2:0] S_RATE_DIV = 3'd2;
    localparam logic [2:0] S_RING     = 3'd3;
    localparam logic [2:0] S_AVG_DIV  = 3'd4;
    localparam logic [2:0] S_DONE     = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                if (!sts.beat)
                begin
                    state_next = S_DONE;
                end
                else if (sts.interval_zero)
                begin
                    state_next = S_RING;
                end
                else
                begin
                    cmd.rate_start = 1'b1;
                    state_next     = S_RATE_DIV;
                end
            end
            S_RATE_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.rate_store = 1'b1;
                    state_next     = S_RING;
                end
            end
            S_RING:
            begin
                cmd.ring_update = 1'b1;
                cmd.avg_start   = 1'b1;
                state_next      = S_AVG_DIV;
            end
            S_AVG_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.avg_store = 1'b1;
                    state_next    = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/ppd_datapath.sv @@
// Datapath: thresholds, detector state, rate ring, shared divider and output register.
`timescale 1ns / 1ps
module ppd_datapath #(
    parameter int RATE_WINDOW = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wen,
    input  logic                          cfg_addr,
    input  logic [ppd_pkg::LEVEL_W-1:0]   cfg_wdata,
    input  logic [ppd_pkg::LEVEL_W-1:0]   in_level,
    input  logic [ppd_pkg::TIME_W-1:0]    in_time,
    input  ppd_pkg::ppd_cmd_t             cmd,
    output ppd_pkg::ppd_status_t          sts,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic                          out_found,
    output logic [ppd_pkg::RATE_W-1:0]    out_rate,
    output logic [ppd_pkg::PEAK_W-1:0]    out_peak,
    output logic [ppd_pkg::PHASE_W-1:0]   out_phase
);
    import ppd_pkg::*;

    localparam int POS_W  = (RATE_WINDOW > 1) ? $clog2(RATE_WINDOW) : 1;
    localparam int FILL_W = $clog2(RATE_WINDOW + 1);
    localparam int SUM_W  = RATE_W + FILL_W;

    logic signed [LEVEL_W-1:0] upper_reg;
    logic signed [LEVEL_W-1:0] lower_reg;

    logic signed [LEVEL_W-1:0] level_reg;
    logic [TIME_W-1:0]         time_reg;

    logic [PHASE_W-1:0]        phase_reg;
    logic signed [LEVEL_W-1:0] prev_reg;
    logic [TIME_W-1:0]         beat_time_reg;
    logic [TIME_W-1:0]         prior_time_reg;
    logic [PEAK_W-1:0]         peak_reg;
    logic [RATE_W-1:0]         ring_reg [RATE_WINDOW];
    logic [POS_W-1:0]          pos_reg;
    logic [FILL_W-1:0]         filled_reg;
    logic [SUM_W-1:0]          sum_reg;
    logic [RATE_W-1:0]         rate_reg;
    logic [RATE_W-1:0]         held_rate_reg;
    logic                      found_reg;

    logic                      out_valid_reg;
    logic                      out_found_reg;
    logic [RATE_W-1:0]         out_rate_reg;
    logic [PEAK_W-1:0]         out_peak_reg;
    logic [PHASE_W-1:0]        out_phase_reg;

    logic                      full_reset;
    logic                      rising;
    logic                      beat;
    logic [TIME_W-1:0]         interval;
    logic [POS_W-1:0]          pos_next;
    logic [FILL_W-1:0]         filled_next;
    logic [SUM_W-1:0]          sum_next;

    logic                      div_start;
    logic [SUM_W-1:0]          div_dividend;
    logic [TIME_W-1:0]         div_divisor;
    logic                      div_done;
    logic [SUM_W-1:0]          div_quotient;

    always_comb
    begin
        full_reset  = level_reg > upper_reg;
        rising      = level_reg > prev_reg;
        beat        = !full_reset && (phase_reg == PHASE_UP) && !rising;
        interval    = beat_time_reg - prior_time_reg;
        pos_next    = (pos_reg == POS_W'(RATE_WINDOW - 1)) ? '0 : pos_reg + 1'b1;
        filled_next = (filled_reg < FILL_W'(RATE_WINDOW)) ? filled_reg + 1'b1 : filled_reg;
        sum_next    = sum_reg - SUM_W'(ring_reg[pos_reg]) + SUM_W'(rate_reg);

        div_start    = cmd.rate_start | cmd.avg_start;
        div_dividend = cmd.avg_start ? sum_next : SUM_W'(RATE_NUMERATOR);
        div_divisor  = cmd.avg_start ? TIME_W'(filled_next) : interval;

        sts.beat          = beat;
        sts.interval_zero = (interval == '0);
        sts.div_done      = div_done;
        sts.out_busy      = out_valid_reg && !out_ready;
    end

    ppd_div #(
        .N_W (SUM_W),
        .D_W (TIME_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg      <= UPPER_RESET;
            lower_reg      <= LOWER_RESET;
            phase_reg      <= PHASE_IDLE;
            prev_reg       <= '0;
            beat_time_reg  <= '0;
            prior_time_reg <= '0;
            peak_reg       <= '0;
            for (int i = 0; i < RATE_WINDOW; i++)
            begin
                ring_reg[i] <= '0;
            end
            pos_reg        <= '0;
            filled_reg     <= '0;
            sum_reg        <= '0;
            held_rate_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_addr)
                    REG_UPPER: upper_reg <= cfg_wdata;
                    REG_LOWER: lower_reg <= cfg_wdata;
                    default:   upper_reg <= upper_reg;
                endcase
            end

            if (cmd.eval)
            begin
                if (full_reset)
                begin
                    phase_reg      <= PHASE_IDLE;
                    prev_reg       <= '0;
                    beat_time_reg  <= '0;
                    prior_time_reg <= '0;
                    peak_reg       <= '0;
                end
                else
                begin
                    case (phase_reg)
                        PHASE_IDLE:
                        begin
                            if (level_reg >= lower_reg)
                            begin
                                phase_reg <= PHASE_UP;
                            end
                            prev_reg <= level_reg;
                        end
                        PHASE_UP:
                        begin
                            if (rising)
                            begin
                                beat_time_reg <= time_reg;
                                peak_reg      <= level_reg[LEVEL_W-1] ? '0
                                                 : level_reg[PEAK_W+7:8];
                                prev_reg      <= level_reg;
                            end
                            else
                            begin
                                prior_time_reg <= beat_time_reg;
                                phase_reg      <= PHASE_DOWN;
                            end
                        end
                        default:
                        begin
                            if (level_reg < lower_reg)
                            begin
                                phase_reg <= PHASE_IDLE;
                            end
                            prev_reg <= level_reg;
                        end
                    endcase
                end
            end

            if (cmd.ring_update)
            begin
                ring_reg[pos_reg] <= rate_reg;
                sum_reg           <= sum_next;
                pos_reg           <= pos_next;
                filled_reg        <= filled_next;
            end

            if (cmd.avg_store)
            begin
                held_rate_reg <= div_quotient[RATE_W-1:0];
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            level_reg <= in_level;
            time_reg  <= in_time;
        end
        if (cmd.eval)
        begin
            found_reg <= beat;
            rate_reg  <= '0;
        end
        if (cmd.rate_store)
        begin
            rate_reg <= div_quotient[RATE_W-1:0];
        end
        if (cmd.out_load)
        begin
            out_found_reg <= found_reg;
            out_rate_reg  <= held_rate_reg;
            out_peak_reg  <= peak_reg;
            out_phase_reg <= phase_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_found = out_found_reg;
    assign out_rate  = out_rate_reg;
    assign out_peak  = out_peak_reg;
    assign out_phase = out_phase_reg;

endmodule

@@ verif/tb_pulse_peak_detector_bpm_core.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the pulse peak detector with its averaged beat rate output.
module tb_pulse_peak_detector_bpm_core;
    import ppd_pkg::*;

    localparam int RING_LEN     = 10;
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 500;
    localparam int DRAIN_CYCLES = 80;
    localparam int LEVEL_MAX    = 8388607;
    localparam int LEVEL_MIN    = -8388608;

    typedef struct packed {
        logic [TIME_W-1:0]  stamp;
        logic [LEVEL_W-1:0] level;
    } sample_t;

    typedef struct packed {
        logic               beat;
        logic [RATE_W-1:0]  rate;
        logic [PEAK_W-1:0]  peak;
        logic [PHASE_W-1:0] phase;
    } beat_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wen = 1'b0;
    logic        cfg_addr = REG_UPPER;
    logic [23:0] cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;

    pulse_peak_detector_bpm_core #(
        .RATE_WINDOW(RING_LEN)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wen(cfg_wen),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    logic signed [LEVEL_W-1:0] upper_thr = UPPER_RESET;
    logic signed [LEVEL_W-1:0] lower_thr = LOWER_RESET;
    logic [PHASE_W-1:0]        trace_phase = PHASE_IDLE;
    logic signed [LEVEL_W-1:0] last_level = '0;
    logic [TIME_W-1:0]         beat_stamp = '0;
    logic [TIME_W-1:0]         prior_stamp = '0;
    logic [PEAK_W-1:0]         peak_hold = '0;
    logic [RATE_W-1:0]         bpm_ring [RING_LEN] = '{default: '0};
    int                        ring_pos = 0;
    int                        ring_count = 0;
    logic [RATE_W-1:0]         avg_rate = '0;

    sample_t      pending_samples[$];
    beat_result_t expected_results[$];
    logic [TIME_W-1:0] clock_ms = '0;

    bit idle_enable = 1'b1;
    int send_gap = 0;
    int ready_gap = 0;
    int hold_left = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int stall_cycles = 0;
    int error_count = 0;
    int samples_sent = 0;
    int beats_seen = 0;
    int full_resets = 0;
    int settings_used = 0;

    task automatic predict_result(input logic signed [LEVEL_W-1:0] level,
                                  input logic [TIME_W-1:0] stamp);
        beat_result_t res;
        logic [31:0]  interval;
        logic [31:0]  bpm;
        logic [31:0]  ring_sum;
        bit           keep;
        res = '0;
        keep = 1'b1;
        if (level > upper_thr)
        begin
            trace_phase = PHASE_IDLE;
            last_level = '0;
            beat_stamp = '0;
            prior_stamp = '0;
            peak_hold = '0;
            keep = 1'b0;
            full_resets++;
        end
        else if (trace_phase == PHASE_IDLE)
        begin
            if (level >= lower_thr)
                trace_phase = PHASE_UP;
        end
        else if (trace_phase == PHASE_UP)
        begin
            if (level > last_level)
            begin
                beat_stamp = stamp;
                peak_hold = level[LEVEL_W-1] ? '0 : level[22:8];
            end
            else
            begin
                interval = beat_stamp - prior_stamp;
                prior_stamp = beat_stamp;
                bpm = (interval == 0) ? 32'd0 : 32'(RATE_NUMERATOR) / interval;
                bpm_ring[ring_pos] = bpm[RATE_W-1:0];
                ring_sum = '0;
                for (int i = 0; i < RING_LEN; i++)
                    ring_sum += 32'(bpm_ring[i]);
                ring_pos = (ring_pos == RING_LEN - 1) ? 0 : ring_pos + 1;
                if (ring_count < RING_LEN)
                    ring_count++;
                avg_rate = 24'(ring_sum / 32'(ring_count));
                trace_phase = PHASE_DOWN;
                res.beat = 1'b1;
                keep = 1'b0;
            end
        end
        else if (level < lower_thr)
        begin
            trace_phase = PHASE_IDLE;
        end
        if (keep)
            last_level = level;
        res.rate = avg_rate;
        res.peak = peak_hold;
        res.phase = trace_phase;
        expected_results.push_back(res);
    endtask

    task automatic check_result(input beat_result_t got);
        beat_result_t want;
        if (got.beat)
            beats_seen++;
        if (expected_results.size() == 0)
        begin
            $display("%0t: unexpected result transfer, expected none, got %p", $time, got);
            error_count++;
        end
        else
        begin
            want = expected_results.pop_front();
            if (got.beat !== want.beat)
            begin
                $display("%0t: beat_found expected %0d got %0d", $time, want.beat, got.beat);
                error_count++;
            end
            if (got.rate !== want.rate)
            begin
                $display("%0t: average_rate expected %0d got %0d", $time, want.rate, got.rate);
                error_count++;
            end
            if (got.peak !== want.peak)
            begin
                $display("%0t: peak_level expected %0d got %0d", $time, want.peak, got.peak);
                error_count++;
            end
            if (got.phase !== want.phase)
            begin
                $display("%0t: detector_phase expected %0d got %0d", $time, want.phase,
                         got.phase);
                error_count++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_result(s_axis_tdata[23:0], s_axis_tdata[55:24]);
                samples_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (idle_enable && $urandom_range(0, 9) == 0)
                begin
                    send_gap <= $urandom_range(0, 12);
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_samples.size() != 0)
                begin
                    s_axis_tdata <= pending_samples.pop_front();
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_result({m_axis_tuser, m_axis_tdata[23:0], m_axis_tdata[38:24],
                              m_axis_tdata[40:39]});
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else if (hold_requests != holds_served)
            begin
                holds_served <= holds_served + 1;
                hold_left <= HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end
            else if (ready_gap > 0)
            begin
                ready_gap <= ready_gap - 1;
                m_axis_tready <= 1'b0;
            end
            else if (idle_enable && $urandom_range(0, 9) == 0)
            begin
                ready_gap <= $urandom_range(0, 12);
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (pending_samples.size() == 0 && !s_axis_tvalid && expected_results.size() == 0))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles with work outstanding", $time,
                     stall_cycles);
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic int pick(int lo_v, int hi_v);
        return lo_v + int'($urandom_range(0, hi_v - lo_v));
    endfunction

    function automatic void add_sample(int level);
        if (level > LEVEL_MAX)
            level = LEVEL_MAX;
        if (level < LEVEL_MIN)
            level = LEVEL_MIN;
        pending_samples.push_back('{stamp: clock_ms, level: level[23:0]});
    endfunction

    function automatic void add_at(int level, logic [TIME_W-1:0] stamp);
        clock_ms = stamp;
        add_sample(level);
    endfunction

    function automatic void add_noise();
        logic [31:0] r;
        r = $urandom();
        clock_ms = $urandom();
        add_sample({{8{r[23]}}, r[23:0]});
    endfunction

    function automatic void tick();
        clock_ms += pick(0, 60);
    endfunction

    // A baseline sample, a rising trace, the beat sample and a short descent, or a cut-off above the upper threshold.
    function automatic int queue_pulse();
        int lo;
        int hi;
        int step_max;
        int level;
        int n;
        lo = lower_thr;
        hi = upper_thr;
        step_max = (hi - lo) / 6 + 1;
        n = 0;
        tick();
        add_sample(lo - pick(1, 30000));
        n++;
        tick();
        level = lo + pick(0, step_max / 2);
        if (level > hi)
            level = hi;
        add_sample(level);
        n++;
        repeat (pick(1, 6))
        begin
            tick();
            if (hi < LEVEL_MAX && pick(0, 11) == 0)
            begin
                add_sample(hi + pick(1, 5000));
                return n + 1;
            end
            level += pick(1, step_max);
            if (level > hi)
                level = hi;
            add_sample(level);
            n++;
        end
        tick();
        level -= pick(0, step_max);
        add_sample(level);
        n++;
        repeat (pick(0, 3))
        begin
            tick();
            level -= pick(0, step_max / 2);
            add_sample(level);
            n++;
        end
        return n;
    endfunction

    function automatic void fill_phase(int count);
        int added;
        int kind;
        added = 0;
        while (added < count)
        begin
            kind = pick(0, 19);
            if (upper_thr < lower_thr || kind < 2)
            begin
                add_noise();
                added++;
            end
            else if (kind == 2 && upper_thr < LEVEL_MAX)
            begin
                tick();
                add_sample(int'(upper_thr) + pick(1, 100000));
                added++;
            end
            else if (kind == 3)
            begin
                clock_ms = (pick(0, 1) == 0) ? $urandom() : 32'hFFFF_FF00 + pick(0, 200);
            end
            else
            begin
                added += queue_pulse();
            end
        end
    endfunction

    task automatic write_thresholds(int upper, int lower);
        @(posedge clk);
        cfg_wen <= 1'b1;
        cfg_addr <= REG_UPPER;
        cfg_wdata <= upper[23:0];
        @(posedge clk);
        cfg_addr <= REG_LOWER;
        cfg_wdata <= lower[23:0];
        @(posedge clk);
        cfg_wen <= 1'b0;
        upper_thr = upper[23:0];
        lower_thr = lower[23:0];
        settings_used++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (pending_samples.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        int upper_set[7];
        int lower_set[7];
        int phase_len[7];
        upper_set = '{512000, LEVEL_MAX, 2000, LEVEL_MIN, 0, 0, 512000};
        lower_set = '{25600, -8388000, -2000, LEVEL_MAX, LEVEL_MIN, 0, 25600};
        phase_len = '{200, 220, 200, 40, 80, 200, 200};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset thresholds: zero interval, wrapped time, equal levels, full resets.
        add_at(LEVEL_MIN, 32'd0);
        add_at(LEVEL_MAX, 32'hFFFF_FFFF);
        add_at(25600, 32'd100);
        add_at(25600, 32'd100);
        add_at(25599, 32'd110);
        add_at(30000, 32'd200);
        add_at(40000, 32'd220);
        add_at(50000, 32'd240);
        add_at(49000, 32'd260);
        add_at(30000, 32'd280);
        add_at(0, 32'd300);
        add_at(26000, 32'hFFFF_FF00);
        add_at(27000, 32'hFFFF_FFF0);
        add_at(26000, 32'd10);
        add_at(100, 32'd20);
        add_at(30000, 32'd30);
        add_at(31000, 32'd40);
        add_at(31000, 32'd50);
        add_at(512000, 32'd60);
        add_at(512001, 32'd70);
        add_at(-1, 32'd80);
        wait_drained();

        for (int p = 0; p < 7; p++)
        begin
            if (p == 5)
            begin
                lower_set[p] = pick(-200000, 200000);
                upper_set[p] = lower_set[p] + pick(2000, 1000000);
            end
            if (p == 6)
                idle_enable = 1'b0;
            write_thresholds(upper_set[p], lower_set[p]);
            fill_phase(phase_len[p]);
            // Hold the result side off long enough that the input side backs up.
            if (p == 1)
                hold_requests++;
            wait_drained();
        end

        $display("Sent %0d samples under %0d threshold settings; %0d beats and %0d full",
                 samples_sent, settings_used, beats_seen, full_resets);
        $display("detector resets were checked, with stalls on both sides of the stream.");
        if (error_count == 0 && expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
